// File: rtl/core/ps2evt_pkg.sv
// ----------------------------------------------------------------------------
// ps2evt_pkg
// Types, constants and the scancode table shared by the PS/2 event translator.
// ----------------------------------------------------------------------------
package ps2evt_pkg;

  localparam int unsigned SCAN_TABLE_ENTRIES = 128;
  localparam int unsigned SCAN_IDX_W         = $clog2(SCAN_TABLE_ENTRIES);

  localparam int unsigned SRC_W   = 8;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COORD_W = 12;
  localparam int unsigned CODE_W  = 32;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [SRC_W-1:0] SRC_KEYBOARD = 8'd1;
  localparam logic [SRC_W-1:0] SRC_MOUSE    = 8'd12;

  localparam logic [0:0] CFG_SCREEN_WIDTH  = 1'b0;
  localparam logic [0:0] CFG_SCREEN_HEIGHT = 1'b1;

  localparam logic [COORD_W-1:0] WIDTH_RST  = 12'd1024;
  localparam logic [COORD_W-1:0] HEIGHT_RST = 12'd768;
  localparam logic [COORD_W-1:0] COL_RST    = 12'd512;
  localparam logic [COORD_W-1:0] ROW_RST    = 12'd384;

  localparam logic [CODE_W-1:0] RELEASE_BIT = 32'h8000_0000;

  typedef enum logic {
    EVT_KEY   = 1'b0,
    EVT_MOUSE = 1'b1
  } evt_kind_t;

  typedef enum logic [1:0] {
    MB_FIRST  = 2'd0,
    MB_SECOND = 2'd1,
    MB_THIRD  = 2'd2
  } mbyte_t;

  typedef struct packed {
    evt_kind_t          kind;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [CODE_W-1:0]  code;
  } evt_t;

  function automatic logic [CODE_W-1:0] key_lookup(input logic [SCAN_IDX_W-1:0] idx);
    logic [CODE_W-1:0] code;
    unique case (idx)
      7'h01:   code = 32'd27;
      7'h02:   code = 32'd49;
      7'h03:   code = 32'd50;
      7'h04:   code = 32'd51;
      7'h05:   code = 32'd52;
      7'h1E:   code = 32'd65;
      7'h30:   code = 32'd66;
      7'h2E:   code = 32'd67;
      7'h20:   code = 32'd68;
      7'h1C:   code = 32'd13;
      7'h39:   code = 32'd32;
      default: code = '0;
    endcase
    return code;
  endfunction

endpackage

// File: rtl/core/ps2evt_decode.sv
// ----------------------------------------------------------------------------
// ps2evt_decode
// Keyboard translation, mouse packet assembly and cursor clamping.
// ----------------------------------------------------------------------------
module ps2evt_decode
  import ps2evt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               item_valid,
  input  logic               step,
  input  logic [SRC_W-1:0]   source_id,
  input  logic [BYTE_W-1:0]  data_byte,
  input  logic [COORD_W-1:0] screen_width,
  input  logic [COORD_W-1:0] screen_height,
  output logic               has_result,
  output evt_t               result
);

  localparam int unsigned SUM_W = COORD_W + 2;

  mbyte_t              mbyte_r, mbyte_nxt;
  logic [BYTE_W-1:0]   flags_r, flags_nxt;
  logic [BYTE_W-1:0]   dx_byte_r, dx_byte_nxt;
  logic [COORD_W-1:0]  col_r, col_nxt;
  logic [COORD_W-1:0]  row_r, row_nxt;

  logic                is_key;
  logic                is_mouse;
  logic                pkt_done;
  logic [CODE_W-1:0]   kbd_code;
  logic signed [SUM_W-1:0] dx;
  logic signed [SUM_W-1:0] dy;
  logic signed [SUM_W-1:0] col_sum;
  logic signed [SUM_W-1:0] row_sum;
  logic [COORD_W-1:0]  width_lim;
  logic [COORD_W-1:0]  height_lim;
  logic [COORD_W-1:0]  col_clamp;
  logic [COORD_W-1:0]  row_clamp;

  assign is_key   = item_valid && (source_id == SRC_KEYBOARD);
  assign is_mouse = item_valid && (source_id == SRC_MOUSE);

  always_comb begin
    pkt_done = 1'b0;
    unique case (mbyte_r)
      MB_FIRST:  pkt_done = 1'b0;
      MB_SECOND: pkt_done = 1'b0;
      default:   pkt_done = is_mouse;
    endcase
  end

  assign kbd_code = key_lookup(data_byte[SCAN_IDX_W-1:0])
                  | (data_byte[BYTE_W-1] ? RELEASE_BIT : '0);

  assign dx = {{(SUM_W-BYTE_W){flags_r[4]}}, dx_byte_r};
  assign dy = {{(SUM_W-BYTE_W){flags_r[5]}}, data_byte};
  assign col_sum = $signed({2'b00, col_r}) + dx;
  assign row_sum = $signed({2'b00, row_r}) - dy;

  assign width_lim  = (screen_width  == '0) ? COORD_W'(1) : screen_width;
  assign height_lim = (screen_height == '0) ? COORD_W'(1) : screen_height;

  always_comb begin
    priority if (col_sum[SUM_W-1]) begin
      col_clamp = '0;
    end else if (col_sum[SUM_W-2:0] >= {1'b0, width_lim}) begin
      col_clamp = width_lim - COORD_W'(1);
    end else begin
      col_clamp = col_sum[COORD_W-1:0];
    end
  end

  always_comb begin
    priority if (row_sum[SUM_W-1]) begin
      row_clamp = '0;
    end else if (row_sum[SUM_W-2:0] >= {1'b0, height_lim}) begin
      row_clamp = height_lim - COORD_W'(1);
    end else begin
      row_clamp = row_sum[COORD_W-1:0];
    end
  end

  // next state
  always_comb begin
    mbyte_nxt   = mbyte_r;
    flags_nxt   = flags_r;
    dx_byte_nxt = dx_byte_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    if (step && is_mouse) begin
      unique case (mbyte_r)
        MB_FIRST: begin
          if (data_byte[3]) begin
            flags_nxt = data_byte;
            mbyte_nxt = MB_SECOND;
          end
        end
        MB_SECOND: begin
          dx_byte_nxt = data_byte;
          mbyte_nxt   = MB_THIRD;
        end
        default: begin
          mbyte_nxt = MB_FIRST;
          col_nxt   = col_clamp;
          row_nxt   = row_clamp;
        end
      endcase
    end
  end

  // outputs
  always_comb begin
    has_result = is_key || pkt_done;
    if (pkt_done) begin
      result.kind = EVT_MOUSE;
      result.x    = col_clamp;
      result.y    = row_clamp;
      result.code = {{(CODE_W-3){1'b0}}, flags_r[2:0]};
    end else begin
      result.kind = EVT_KEY;
      result.x    = col_r;
      result.y    = row_r;
      result.code = kbd_code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mbyte_r <= MB_FIRST;
      col_r   <= COL_RST;
      row_r   <= ROW_RST;
    end else begin
      mbyte_r <= mbyte_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    flags_r   <= flags_nxt;
    dx_byte_r <= dx_byte_nxt;
  end

`ifndef ASSERT_OFF
  a_mouse_evt_on_third: assert property (@(posedge clk) disable iff (!rst_n)
    (has_result && result.kind == EVT_MOUSE) |-> (mbyte_r != MB_FIRST && mbyte_r != MB_SECOND))
    else $error("mouse event without a complete packet");
  a_first_byte_sync: assert property (@(posedge clk) disable iff (!rst_n)
    (step && is_mouse && mbyte_r == MB_FIRST && !data_byte[3]) |=> (mbyte_r == MB_FIRST))
    else $error("unsynchronized first byte accepted");
  a_cursor_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (step && !pkt_done) |=> ($stable(col_r) && $stable(row_r)))
    else $error("cursor moved without a packet");
`endif

endmodule

// File: rtl/core/ps2_keyboard_mouse_event_translator.sv
// ----------------------------------------------------------------------------
// ps2_keyboard_mouse_event_translator
// Turns tagged PS/2 keyboard and mouse bytes into key and cursor events.
//
//   channel  direction  handshake          payload
//   in_      input      valid / stall      source_id, data_byte
//   out_     output     valid / stall      event_kind, cursor_x, cursor_y, evt_code
//   cfg_     input      valid / ready      index, data (screen width, height)
//
// One byte per cycle while in_stall is low; each byte passes the input register
// and, if it bears a result, the result register, set by the single add-and-clamp stage.
// Reset clears the pipeline valid bits, mouse packet position and cursor
// (512, 384); screen size returns to 1024 x 768. No clearing pass.
// A stalled result holds; the input stalls only when the input register
// holds a result-bearing byte that cannot move into the result register.
// ----------------------------------------------------------------------------
module ps2_keyboard_mouse_event_translator
  import ps2evt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [SRC_W-1:0]     in_source_id,
  input  logic [BYTE_W-1:0]    in_data_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_event_kind,
  output logic [COORD_W-1:0]   out_cursor_x,
  output logic [COORD_W-1:0]   out_cursor_y,
  output logic [CODE_W-1:0]    out_evt_code,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_data
);

  logic                s1_valid_r, s1_valid_nxt;
  logic [SRC_W-1:0]    s1_src_r;
  logic [BYTE_W-1:0]   s1_byte_r;
  logic                out_valid_r, out_valid_nxt;
  evt_t                out_r;
  logic [COORD_W-1:0]  width_r, height_r;

  logic                has_res;
  evt_t                res;
  logic                out_free;
  logic                s1_adv;
  logic                in_xfer;
  logic                out_load;

  ps2evt_decode u_decode (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_valid    (s1_valid_r),
    .step          (s1_adv),
    .source_id     (s1_src_r),
    .data_byte     (s1_byte_r),
    .screen_width  (width_r),
    .screen_height (height_r),
    .has_result    (has_res),
    .result        (res)
  );

  assign out_free      = !out_valid_r || !out_stall;
  assign s1_adv        = s1_valid_r && (!has_res || out_free);
  assign in_stall      = s1_valid_r && has_res && !out_free;
  assign in_xfer       = in_valid && !in_stall;
  assign out_load      = s1_adv && has_res;
  assign s1_valid_nxt  = in_xfer || (s1_valid_r && !s1_adv);
  assign out_valid_nxt = out_load || (out_valid_r && out_stall);
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      width_r     <= WIDTH_RST;
      height_r    <= HEIGHT_RST;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_SCREEN_WIDTH:  width_r  <= cfg_data;
          CFG_SCREEN_HEIGHT: height_r <= cfg_data;
          default:           width_r  <= width_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_src_r  <= in_source_id;
      s1_byte_r <= in_data_byte;
    end
    if (out_load) begin
      out_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_event_kind = out_r.kind;
  assign out_cursor_x   = out_r.x;
  assign out_cursor_y   = out_r.y;
  assign out_evt_code   = out_r.code;

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && has_res && out_valid_r && out_stall) |-> (in_stall && !s1_adv))
    else $error("pending result would be overwritten");
  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && has_res) |=> out_valid_r)
    else $error("result lost between stages");
  a_mouse_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.kind == EVT_MOUSE) |->
      (out_r.x != {COORD_W{1'b1}} && out_r.y != {COORD_W{1'b1}}))
    else $error("mouse cursor outside clamp range");
`endif

endmodule
